// ----- rtl/core/sorted_priority_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion helpers shared by the RTL of the sorted priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`else

`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, operation and status codes, and entry and compare types.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default capacity of the queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Fixed word widths.
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // One stored queue entry.
    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } t_entry;

    // Outcome of the priority compare unit.
    typedef struct packed {
        logic greater;
        logic equal;
        logic shift;
    } t_cmp_res;

endpackage
`default_nettype wire

// ----- rtl/core/sorted_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of value and priority pairs kept in ascending priority order.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one request word (func, value, priority)
// with valid and stall; the output channel returns one result word (head
// value, status, count, empty, full) for every request. A request is taken
// only while the sequencer is idle, so o_in_stall is high while a request
// is in progress.
// Clear, rejected requests and an insert into an empty queue go straight to
// the done state; read and a take of the only entry pass through the head
// state first. An insert walks down from the tail one entry per cycle until
// it finds its slot, and a take walks the remaining entries up one per cycle
// toward the head; the entry memory, with one entry moved per cycle through
// its registered read port, sets the pace of both walks. From the done state
// the result word goes to the output register once that register is free,
// and only then does the sequencer return to idle for the next request.
// Reset empties the queue and drops any pending result. A stalled result
// stays in the output register; the next request may be accepted meanwhile,
// and its result waits until the output register is free.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH),
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [spq_pkg::FUNC_W-1:0]          i_func,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   i_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   i_priority_req,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]        o_head_value,
    output logic [spq_pkg::STATUS_W-1:0]             o_status,
    output logic [CW-1:0]                            o_count,
    output logic                                     o_is_empty,
    output logic                                     o_is_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_SHIFT_DN,
        S_INS,
        S_INS_HEAD,
        S_DONE
    } t_state;

    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    t_state                             r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [AW-1:0]                      r_idx, n_idx;
    logic [spq_pkg::FUNC_W-1:0]         r_func, n_func;
    spq_pkg::t_entry                    r_new, n_new;
    logic signed [spq_pkg::DATA_W-1:0]  r_head, n_head;
    logic [spq_pkg::STATUS_W-1:0]       r_status, n_status;
    logic                               r_out_valid, n_out_valid;
    logic signed [spq_pkg::DATA_W-1:0]  r_out_head;
    logic [spq_pkg::STATUS_W-1:0]       r_out_status;
    logic [CW-1:0]                      r_out_count;
    logic                               r_out_empty, r_out_full;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    spq_pkg::t_entry     mem_wdata, mem_rdata;
    spq_pkg::t_cmp_res   cmp_res;
    logic                out_free;
    logic                load_out;
    logic [AW:0]         idx_up;
    logic [AW-1:0]       idx_dn;
    logic [CW-1:0]       tail_idx;

    // Entry memory.
    spq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared priority compare, used once per step of the insert walk.
    spq_cmp u_cmp (
        .i_entry_prio (mem_rdata.prio),
        .i_req_prio   (r_new.prio),
        .i_at_head    (r_idx == '0),
        .o_res        (cmp_res)
    );

    // Index arithmetic for the walks.
    assign idx_up   = {1'b0, r_idx} + 1'b1;
    assign idx_dn   = r_idx - 1'b1;
    assign tail_idx = r_count - 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = (r_state == S_DONE) && out_free;

    // Sequencer next state and memory control.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_func      = r_func;
        n_new       = r_new;
        n_head      = r_head;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_new;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func     = i_func;
                    n_new.prio  = i_priority_req;
                    n_new.value = i_value;
                    n_head     = '0;
                    n_status   = spq_pkg::STATUS_OK;
                    n_state    = S_DONE;
                    case (i_func)
                        spq_pkg::FUNC_INSERT: begin
                            if (r_count == DEPTH_C) begin
                                n_status = spq_pkg::STATUS_FULL;
                            end else if (r_count == '0) begin
                                mem_we          = 1'b1;
                                mem_wdata.prio  = i_priority_req;
                                mem_wdata.value = i_value;
                                n_count         = r_count + 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = tail_idx[AW-1:0];
                                n_idx     = tail_idx[AW-1:0];
                                n_state   = S_INS;
                            end
                        end
                        spq_pkg::FUNC_TAKE,
                        spq_pkg::FUNC_READ: begin
                            if (r_count == '0) begin
                                n_status = spq_pkg::STATUS_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_HEAD;
                            end
                        end
                        spq_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Head word has arrived from the memory.
            S_HEAD: begin
                n_head  = mem_rdata.value;
                n_state = S_DONE;
                if (r_func == spq_pkg::FUNC_TAKE) begin
                    if (r_count > CW'(1)) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(1);
                        n_idx     = AW'(1);
                        n_state   = S_SHIFT_DN;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
            end

            // Move each remaining entry one place toward the head.
            S_SHIFT_DN: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dn;
                mem_wdata = mem_rdata;
                if (CW'(idx_up) < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_up[AW-1:0];
                    n_idx     = idx_up[AW-1:0];
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end

            // Walk from the tail, moving entries up until the slot is found.
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = idx_up[AW-1:0];
                if (cmp_res.shift) begin
                    mem_wdata = mem_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_dn;
                        n_idx     = idx_dn;
                    end
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end

            // Every entry moved up: the new one becomes the head.
            S_INS_HEAD: begin
                mem_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end

            // Hand the result word to the output register.
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_func      <= n_func;
            r_new       <= n_new;
            r_head      <= n_head;
            r_status    <= n_status;
            if (load_out) begin
                r_out_head   <= r_head;
                r_out_status <= r_status;
                r_out_count  <= r_count;
                r_out_empty  <= (r_count == '0);
                r_out_full   <= (r_count == DEPTH_C);
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_head_value = r_out_head;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_is_empty   = r_out_empty;
    assign o_is_full    = r_out_full;

    // Occupancy never exceeds the capacity.
    `SPQ_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)

    // The insert walk stays inside the occupied entries.
    `SPQ_ASSERT_SAME(a_ins_idx, i_clk, i_rst_n, r_state == S_INS, CW'(r_idx) < r_count)

    // A rejected insert is reported only when the queue is really full.
    `SPQ_ASSERT_SAME(a_full_status, i_clk, i_rst_n,
        r_state == S_DONE && r_status == spq_pkg::STATUS_FULL, r_count == DEPTH_C)

    // A finished request is presented on the output in the next cycle.
    `SPQ_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, load_out,
        o_out_valid && o_count == $past(r_count))

endmodule
`default_nettype wire

// ----- rtl/core/spq_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire spq_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output spq_pkg::t_entry      o_rdata
);

    spq_pkg::t_entry r_mem [DEPTH];
    spq_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/core/spq_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue compare unit
// Signed priority compare that decides whether a stored entry moves up.
// ----------------------------------------------------------------------------
module spq_cmp (
    input  wire logic signed [spq_pkg::DATA_W-1:0] i_entry_prio,
    input  wire logic signed [spq_pkg::DATA_W-1:0] i_req_prio,
    input  wire logic                              i_at_head,
    output spq_pkg::t_cmp_res                      o_res
);

    // An entry of greater priority always makes room; an equal one does so
    // unless it is the head, which a new entry of equal priority never displaces.
    always_comb begin
        o_res.greater = (i_entry_prio > i_req_prio);
        o_res.equal   = (i_entry_prio == i_req_prio);
        o_res.shift   = o_res.greater || (o_res.equal && !i_at_head);
    end

endmodule
`default_nettype wire

// ----- sim/tb_sorted_priority_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert, take, read and clear requests into the queue and checks every
// result word against a behavioral copy of the queue kept here. A short table
// covers the empty and full corners, equal priorities and the extreme values,
// then random traffic runs in three phases with different idle patterns on
// both channels, including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

    localparam int QD             = spq_pkg::QUEUE_DEPTH_DEF;
    localparam int DW             = spq_pkg::DATA_W;
    localparam int FW             = spq_pkg::FUNC_W;
    localparam int SW             = spq_pkg::STATUS_W;
    localparam int CNT_W          = $clog2(QD + 1);
    localparam int RAND_PER_PHASE = 275;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [DW-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DW-1:0] WORD_MAX = 32'sh7fff_ffff;

    // One result word as the block reports it.
    typedef struct packed {
        logic signed [DW-1:0] head_value;
        logic [SW-1:0]        status;
        logic [CNT_W-1:0]     count;
        logic                 is_empty;
        logic                 is_full;
    } t_result;

    // One line of the directed table; rep repeats an insert with value + k.
    typedef struct packed {
        logic [FW-1:0]        op;
        logic signed [DW-1:0] value;
        logic signed [DW-1:0] prio;
        int                   rep;
        logic                 fixed;
        t_result              want;
    } t_row;

    localparam t_result NO_WANT   = '0;
    localparam t_result EMPTY_HIT = '{32'sd0, spq_pkg::STATUS_EMPTY, 5'd0, 1'b1, 1'b0};
    localparam t_result CLEARED   = '{32'sd0, spq_pkg::STATUS_OK, 5'd0, 1'b1, 1'b0};

    localparam int N_ROWS = 13;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{spq_pkg::FUNC_READ,   32'sd0,      32'sd0,   1, 1'b1, EMPTY_HIT},
        '{spq_pkg::FUNC_TAKE,   32'sd0,      32'sd0,   1, 1'b1, EMPTY_HIT},
        '{spq_pkg::FUNC_CLEAR,  32'sd0,      32'sd0,   1, 1'b1, CLEARED},
        '{spq_pkg::FUNC_INSERT, WORD_MAX,    32'sd0,   1, 1'b1,
          '{32'sd0, spq_pkg::STATUS_OK, 5'd1, 1'b0, 1'b0}},
        // Same priority as the head: must land right behind it.
        '{spq_pkg::FUNC_INSERT, WORD_MIN,    32'sd0,   1, 1'b0, NO_WANT},
        '{spq_pkg::FUNC_READ,   32'sd0,      32'sd0,   1, 1'b1,
          '{WORD_MAX, spq_pkg::STATUS_OK, 5'd2, 1'b0, 1'b0}},
        '{spq_pkg::FUNC_INSERT, -32'sd1,     WORD_MIN, 1, 1'b0, NO_WANT},
        '{spq_pkg::FUNC_INSERT, 32'sd1,      WORD_MAX, 1, 1'b0, NO_WANT},
        '{spq_pkg::FUNC_TAKE,   32'sd0,      32'sd0,   1, 1'b0, NO_WANT},
        // Fill up with ties that sit behind the head, not on it.
        '{spq_pkg::FUNC_INSERT, 32'sd100,    32'sd0,  13, 1'b0, NO_WANT},
        '{spq_pkg::FUNC_INSERT, 32'sd7,      -32'sd5,  1, 1'b1,
          '{32'sd0, spq_pkg::STATUS_FULL, 5'd16, 1'b0, 1'b1}},
        '{spq_pkg::FUNC_TAKE,   32'sd0,      32'sd0,   1, 1'b0, NO_WANT},
        '{spq_pkg::FUNC_CLEAR,  32'sd0,      32'sd0,   1, 1'b1, CLEARED}
    };

    // Block ports.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [FW-1:0]        i_func;
    logic signed [DW-1:0] i_value;
    logic signed [DW-1:0] i_priority_req;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [DW-1:0] o_head_value;
    logic [SW-1:0]        o_status;
    logic [CNT_W-1:0]     o_count;
    logic                 o_is_empty;
    logic                 o_is_full;

    // Typed expectation that travels with a directed request word.
    logic    req_fixed;
    t_result req_want;

    // Behavioral copy of the queue contents.
    logic signed [DW-1:0] slot_val  [QD];
    logic signed [DW-1:0] slot_prio [QD];
    int                   held;

    // Results still owed by the block, oldest first.
    t_result owed_results [$];

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_start;
    int  hold_left;
    int  idle_cycles;
    int  n_errors;
    int  n_results;
    int  n_full_rejects;
    int  n_empty_misses;
    int  peak_held;
    int  op_seen [4];

    sorted_priority_queue #(
        .QUEUE_DEPTH(QD)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_head_value   (o_head_value),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the queue copy and return the result word it owes.
    function automatic t_result apply_request(input logic [FW-1:0] op,
                                              input logic signed [DW-1:0] val,
                                              input logic signed [DW-1:0] pri);
        t_result res;
        int      slot;
        int      i;
        res = '0;
        res.status = spq_pkg::STATUS_OK;
        case (op)
            spq_pkg::FUNC_INSERT: begin
                if (held == QD) begin
                    res.status = spq_pkg::STATUS_FULL;
                    n_full_rejects++;
                end else begin
                    // First slot whose priority is not below the new one,
                    // but never in front of a head of equal priority.
                    slot = 0;
                    while (slot < held && slot_prio[slot] < pri)
                        slot++;
                    if (slot == 0 && held > 0 && slot_prio[0] == pri)
                        slot = 1;
                    for (i = held; i > slot; i--) begin
                        slot_val[i]  = slot_val[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_val[slot]  = val;
                    slot_prio[slot] = pri;
                    held++;
                end
            end
            spq_pkg::FUNC_TAKE: begin
                if (held == 0) begin
                    res.status = spq_pkg::STATUS_EMPTY;
                    n_empty_misses++;
                end else begin
                    res.head_value = slot_val[0];
                    for (i = 1; i < held; i++) begin
                        slot_val[i-1]  = slot_val[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    held--;
                end
            end
            spq_pkg::FUNC_READ: begin
                if (held == 0) begin
                    res.status = spq_pkg::STATUS_EMPTY;
                    n_empty_misses++;
                end else begin
                    res.head_value = slot_val[0];
                end
            end
            default: begin
                held = 0;
            end
        endcase
        res.count    = CNT_W'(held);
        res.is_empty = (held == 0);
        res.is_full  = (held == QD);
        if (held > peak_held)
            peak_held = held;
        return res;
    endfunction

    // Count a failure and show the first few in detail.
    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("mismatch %0d (%s): want head=%0d status=%0d count=%0d empty=%0b full=%0b",
                     n_errors, what, want.head_value, want.status, want.count,
                     want.is_empty, want.is_full);
            $display("    got head=%0d status=%0d count=%0d empty=%0b full=%0b",
                     got.head_value, got.status, got.count, got.is_empty, got.is_full);
        end
    endtask

    // Offer one request word after a random idle gap and wait until it is taken.
    // Entered and left at a falling edge.
    task automatic offer(input logic [FW-1:0] op,
                         input logic signed [DW-1:0] val,
                         input logic signed [DW-1:0] pri,
                         input logic fixed, input t_result want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= op;
        i_value        <= val;
        i_priority_req <= pri;
        req_fixed      <= fixed;
        req_want       <= want;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (owed_results.size() != 0);
    endtask

    // Output stall: a long hold-off on request, otherwise random per cycle.
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Predict on every accepted request word, then check every accepted result.
    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                want = apply_request(i_func, i_value, i_priority_req);
                if (req_fixed)
                    want = req_want;
                owed_results.push_back(want);
                op_seen[i_func]++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_head_value, o_status, o_count, o_is_empty, o_is_full};
                n_results++;
                if (owed_results.size() == 0) begin
                    report_mismatch("result with nothing pending", NO_WANT, got);
                end else begin
                    want = owed_results.pop_front();
                    if (got.head_value !== want.head_value || got.status !== want.status ||
                        got.count !== want.count || got.is_empty !== want.is_empty ||
                        got.is_full !== want.is_full)
                        report_mismatch("field differs", want, got);
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_sorted_priority_queue: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        logic [FW-1:0]        op;
        logic signed [DW-1:0] val;
        logic signed [DW-1:0] pri;
        int                   r;
        bit                   fill_bias;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = spq_pkg::FUNC_READ;
        i_value        = '0;
        i_priority_req = '0;
        i_out_stall    = 1'b0;
        req_fixed      = 1'b0;
        req_want       = NO_WANT;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        hold_start     = 1'b0;
        hold_left      = 0;
        idle_cycles    = 0;
        n_errors       = 0;
        n_results      = 0;
        n_full_rejects = 0;
        n_empty_misses = 0;
        peak_held      = 0;
        held           = 0;
        fill_bias      = 1'b0;
        foreach (op_seen[k])
            op_seen[k] = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty and full corners, ties and extreme words.
        tx_idle_pct = 20;
        rx_idle_pct = 30;
        for (int row = 0; row < N_ROWS; row++) begin
            for (int k = 0; k < DIRECTED[row].rep; k++)
                offer(DIRECTED[row].op, DIRECTED[row].value + k, DIRECTED[row].prio,
                      DIRECTED[row].fixed, DIRECTED[row].want);
        end
        wait_drain();

        // Random traffic in three idle patterns; bursts lean toward filling
        // or draining so that both the full and the empty corners recur.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 80 : 0;
            rx_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 35 : 0;
            hold_start  = 1'b1;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % 32 == 0)
                    fill_bias = $urandom_range(1);
                r = $urandom_range(99);
                if (r < (fill_bias ? 65 : 25))
                    op = spq_pkg::FUNC_INSERT;
                else if (r < 80)
                    op = spq_pkg::FUNC_TAKE;
                else if (r < 97)
                    op = spq_pkg::FUNC_READ;
                else
                    op = spq_pkg::FUNC_CLEAR;
                val = $urandom;
                r = $urandom_range(99);
                if (r < 35) begin
                    pri = int'($urandom_range(7)) - 3;
                end else if (r < 45) begin
                    case ($urandom_range(3))
                        0: pri = WORD_MIN;
                        1: pri = WORD_MAX;
                        2: pri = -32'sd1;
                        default: pri = 32'sd0;
                    endcase
                end else begin
                    pri = $urandom;
                end
                offer(op, val, pri, 1'b0, NO_WANT);
            end
            wait_drain();
        end

        // Let any stray result show up before the verdict.
        repeat (QD + 8) @(negedge i_clk);
        if (owed_results.size() != 0)
            report_mismatch("result never arrived", owed_results[0], NO_WANT);

        $display("covered %0d requests: %0d insert, %0d take, %0d read, %0d clear; %0d results",
                 op_seen[spq_pkg::FUNC_INSERT] + op_seen[spq_pkg::FUNC_TAKE] +
                 op_seen[spq_pkg::FUNC_READ] + op_seen[spq_pkg::FUNC_CLEAR],
                 op_seen[spq_pkg::FUNC_INSERT], op_seen[spq_pkg::FUNC_TAKE],
                 op_seen[spq_pkg::FUNC_READ], op_seen[spq_pkg::FUNC_CLEAR], n_results);
        $display("peak occupancy %0d of %0d, %0d inserts refused full, %0d empty misses",
                 peak_held, QD, n_full_rejects, n_empty_misses);
        if (n_errors == 0)
            $display("tb_sorted_priority_queue: done, clean");
        else
            $display("tb_sorted_priority_queue: done, errors");
        $finish;
    end

endmodule
